// ----- hw/rtl/pump_motion_safety_watchdog_core_assert.svh -----
// Assertion macros used by the checker file pmsw_checker.sv.
`ifndef PUMP_MOTION_SAFETY_WATCHDOG_CORE_ASSERT_SVH
`define PUMP_MOTION_SAFETY_WATCHDOG_CORE_ASSERT_SVH

// Same-cycle implication.
`define PMSW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define PMSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- hw/rtl/pmsw_pkg.sv -----
`timescale 1ns / 1ps

package pmsw_pkg;

   localparam logic [3:0] FUNC_INIT         = 4'd0;
   localparam logic [3:0] FUNC_CHECK        = 4'd1;
   localparam logic [3:0] FUNC_AGENT_PUMP   = 4'd2;
   localparam logic [3:0] FUNC_WEB_PUMP     = 4'd3;
   localparam logic [3:0] FUNC_PUMP_OFF     = 4'd4;
   localparam logic [3:0] FUNC_MOTION_STOP  = 4'd5;
   localparam logic [3:0] FUNC_AGENT_MOTION = 4'd6;
   localparam logic [3:0] FUNC_WEB_MOTION   = 4'd7;
   localparam logic [3:0] FUNC_AGENT_STATE  = 4'd8;

   localparam logic [1:0] SRC_NONE  = 2'd0;
   localparam logic [1:0] SRC_AGENT = 2'd1;
   localparam logic [1:0] SRC_WEB   = 2'd2;

   localparam logic [1:0] MCAUSE_NONE    = 2'd0;
   localparam logic [1:0] MCAUSE_STOP    = 2'd1;
   localparam logic [1:0] MCAUSE_LOST    = 2'd2;
   localparam logic [1:0] MCAUSE_TIMEOUT = 2'd3;

   localparam logic [2:0] PCAUSE_NONE     = 3'd0;
   localparam logic [2:0] PCAUSE_REJECTED = 3'd1;
   localparam logic [2:0] PCAUSE_LOST     = 3'd2;
   localparam logic [2:0] PCAUSE_TIMEOUT  = 3'd3;
   localparam logic [2:0] PCAUSE_OFF      = 3'd4;

   localparam logic [1:0] CSR_PUMP_TIMEOUT     = 2'd0;
   localparam logic [1:0] CSR_MOTION_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_PUMP_ACTIVE_HIGH = 2'd2;

   localparam logic [31:0] PUMP_TIMEOUT_RST   = 32'd0;
   localparam logic [31:0] MOTION_TIMEOUT_RST = 32'd500;

   typedef struct packed {
      logic [31:0] pump_timeout;
      logic [31:0] motion_timeout;
      logic        pump_active_high;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] now_ms;
      logic        pump_request_on;
      logic        agent_link;
   } item_type;

   typedef struct packed {
      logic       pump_drive;
      logic       pump_enabled;
      logic       motion_stop;
      logic [1:0] motion_cause;
      logic [2:0] pump_cause;
   } result_type;

endpackage

// ----- hw/rtl/pmsw_cfg.sv -----
`timescale 1ns / 1ps

module pmsw_cfg (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [1:0]       wr_index,
   input  logic [31:0]      wr_data,
   output pmsw_pkg::cfg_type cfg
);

   pmsw_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            pmsw_pkg::CSR_PUMP_TIMEOUT:     cfg_in.pump_timeout     = wr_data;
            pmsw_pkg::CSR_MOTION_TIMEOUT:   cfg_in.motion_timeout   = wr_data;
            pmsw_pkg::CSR_PUMP_ACTIVE_HIGH: cfg_in.pump_active_high = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pump_timeout     <= pmsw_pkg::PUMP_TIMEOUT_RST;
         cfg_ff.motion_timeout   <= pmsw_pkg::MOTION_TIMEOUT_RST;
         cfg_ff.pump_active_high <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/pmsw_engine.sv -----
`timescale 1ns / 1ps

module pmsw_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  pmsw_pkg::item_type   item,
   input  pmsw_pkg::cfg_type    cfg,
   output pmsw_pkg::result_type result
);

   logic        initialized_ff, initialized_in;
   logic        link_up_ff, link_up_in;
   logic        pump_on_ff, pump_on_in;
   logic [1:0]  pump_source_ff, pump_source_in;
   logic [31:0] pump_stamp_ff, pump_stamp_in;
   logic [1:0]  motion_source_ff, motion_source_in;
   logic [31:0] motion_stamp_ff, motion_stamp_in;

   logic [31:0] motion_elapsed;
   logic [31:0] pump_elapsed;
   logic        motion_expired;
   logic        pump_expired;
   logic        mstop;
   logic [1:0]  mcause;
   logic [2:0]  pcause;

   assign motion_elapsed = item.now_ms - motion_stamp_ff;
   assign pump_elapsed   = item.now_ms - pump_stamp_ff;
   assign motion_expired = (cfg.motion_timeout != 32'd0) && (motion_elapsed > cfg.motion_timeout);
   assign pump_expired   = (cfg.pump_timeout != 32'd0) && (pump_elapsed > cfg.pump_timeout);

   always_comb begin
      initialized_in   = initialized_ff;
      link_up_in       = link_up_ff;
      pump_on_in       = pump_on_ff;
      pump_source_in   = pump_source_ff;
      pump_stamp_in    = pump_stamp_ff;
      motion_source_in = motion_source_ff;
      motion_stamp_in  = motion_stamp_ff;
      mstop            = 1'b0;
      mcause           = pmsw_pkg::MCAUSE_NONE;
      pcause           = pmsw_pkg::PCAUSE_NONE;

      case (item.func)
         pmsw_pkg::FUNC_INIT: begin
            initialized_in   = 1'b1;
            link_up_in       = item.agent_link;
            pump_stamp_in    = item.now_ms;
            pump_source_in   = pmsw_pkg::SRC_NONE;
            motion_stamp_in  = item.now_ms;
            motion_source_in = pmsw_pkg::SRC_NONE;
            pump_on_in       = 1'b0;
         end
         pmsw_pkg::FUNC_CHECK: begin
            if (motion_source_ff != pmsw_pkg::SRC_NONE) begin
               if (motion_source_ff == pmsw_pkg::SRC_AGENT && !link_up_ff) begin
                  mstop  = 1'b1;
                  mcause = pmsw_pkg::MCAUSE_LOST;
               end else if (motion_expired) begin
                  mstop  = 1'b1;
                  mcause = pmsw_pkg::MCAUSE_TIMEOUT;
               end
            end
            if (mstop) begin
               motion_source_in = pmsw_pkg::SRC_NONE;
               motion_stamp_in  = item.now_ms;
            end
            if (pump_on_ff && pump_source_ff == pmsw_pkg::SRC_AGENT && !link_up_ff) begin
               pcause = pmsw_pkg::PCAUSE_LOST;
            end else if (pump_on_ff && pump_expired) begin
               pcause = pmsw_pkg::PCAUSE_TIMEOUT;
            end
            if (pcause != pmsw_pkg::PCAUSE_NONE) begin
               pump_stamp_in  = item.now_ms;
               pump_source_in = pmsw_pkg::SRC_NONE;
               if (initialized_ff) begin
                  pump_on_in = 1'b0;
               end
            end
         end
         pmsw_pkg::FUNC_AGENT_PUMP: begin
            pump_stamp_in = item.now_ms;
            if (item.pump_request_on && !link_up_ff) begin
               pump_source_in = pmsw_pkg::SRC_NONE;
               pcause         = pmsw_pkg::PCAUSE_REJECTED;
               if (initialized_ff) begin
                  pump_on_in = 1'b0;
               end
            end else begin
               pump_source_in = item.pump_request_on ? pmsw_pkg::SRC_AGENT : pmsw_pkg::SRC_NONE;
               if (initialized_ff) begin
                  pump_on_in = item.pump_request_on;
               end
            end
         end
         pmsw_pkg::FUNC_WEB_PUMP: begin
            pump_stamp_in  = item.now_ms;
            pump_source_in = item.pump_request_on ? pmsw_pkg::SRC_WEB : pmsw_pkg::SRC_NONE;
            if (initialized_ff) begin
               pump_on_in = item.pump_request_on;
            end
         end
         pmsw_pkg::FUNC_PUMP_OFF: begin
            pump_stamp_in  = item.now_ms;
            pump_source_in = pmsw_pkg::SRC_NONE;
            pcause         = pmsw_pkg::PCAUSE_OFF;
            if (initialized_ff) begin
               pump_on_in = 1'b0;
            end
         end
         pmsw_pkg::FUNC_MOTION_STOP: begin
            motion_source_in = pmsw_pkg::SRC_NONE;
            motion_stamp_in  = item.now_ms;
            mstop            = 1'b1;
            mcause           = pmsw_pkg::MCAUSE_STOP;
         end
         pmsw_pkg::FUNC_AGENT_MOTION: begin
            motion_stamp_in  = item.now_ms;
            motion_source_in = pmsw_pkg::SRC_AGENT;
         end
         pmsw_pkg::FUNC_WEB_MOTION: begin
            motion_stamp_in  = item.now_ms;
            motion_source_in = pmsw_pkg::SRC_WEB;
         end
         pmsw_pkg::FUNC_AGENT_STATE: begin
            link_up_in = item.agent_link;
            if (!item.agent_link && motion_source_ff == pmsw_pkg::SRC_AGENT) begin
               motion_source_in = pmsw_pkg::SRC_NONE;
               motion_stamp_in  = item.now_ms;
               mstop            = 1'b1;
               mcause           = pmsw_pkg::MCAUSE_LOST;
            end
            if (!item.agent_link && pump_source_ff == pmsw_pkg::SRC_AGENT) begin
               pump_stamp_in  = item.now_ms;
               pump_source_in = pmsw_pkg::SRC_NONE;
               pcause         = pmsw_pkg::PCAUSE_LOST;
               if (initialized_ff) begin
                  pump_on_in = 1'b0;
               end
            end
         end
         default: ;
      endcase

      result.pump_drive   = pump_on_in ? cfg.pump_active_high : ~cfg.pump_active_high;
      result.pump_enabled = pump_on_in;
      result.motion_stop  = mstop;
      result.motion_cause = mcause;
      result.pump_cause   = pcause;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff   <= 1'b0;
         link_up_ff       <= 1'b0;
         pump_on_ff       <= 1'b0;
         pump_source_ff   <= pmsw_pkg::SRC_NONE;
         pump_stamp_ff    <= 32'd0;
         motion_source_ff <= pmsw_pkg::SRC_NONE;
         motion_stamp_ff  <= 32'd0;
      end else if (fire) begin
         initialized_ff   <= initialized_in;
         link_up_ff       <= link_up_in;
         pump_on_ff       <= pump_on_in;
         pump_source_ff   <= pump_source_in;
         pump_stamp_ff    <= pump_stamp_in;
         motion_source_ff <= motion_source_in;
         motion_stamp_ff  <= motion_stamp_in;
      end
   end

endmodule

// ----- hw/rtl/pump_motion_safety_watchdog_core.sv -----
`timescale 1ns / 1ps

// Pump and motion safety watchdog. Each request (func, now_ms, pump_request_on,
// agent_link) gives exactly one response with the pump pin level, the
// logical pump state and any motion stop or pump shutdown cause. A request is
// registered on acceptance; its response is computed from that registered
// request against the tracked command state and is registered in result_ff,
// which raises rsp_valid. One request is taken per cycle while rsp_stall does
// not hold the response. Configuration writes on the
// csr_ port are always ready and should only be made while no request is in
// flight. csr_index 3 is ignored.
module pump_motion_safety_watchdog_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic        req_pump_request_on,
   input  logic        req_agent_link,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pump_drive,
   output logic        rsp_pump_enabled,
   output logic        rsp_motion_stop,
   output logic [1:0]  rsp_motion_cause,
   output logic [2:0]  rsp_pump_cause,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   pmsw_pkg::cfg_type    cfg;
   pmsw_pkg::item_type   item_ff, item_in;
   pmsw_pkg::result_type result_ff, result_in;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_accept;

   assign csr_ready  = 1'b1;
   assign advance    = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = item_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign item_in.func            = req_func;
   assign item_in.now_ms          = req_now_ms;
   assign item_in.pump_request_on = req_pump_request_on;
   assign item_in.agent_link      = req_agent_link;

   pmsw_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   pmsw_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pump_drive   = result_ff.pump_drive;
   assign rsp_pump_enabled = result_ff.pump_enabled;
   assign rsp_motion_stop  = result_ff.motion_stop;
   assign rsp_motion_cause = result_ff.motion_cause;
   assign rsp_pump_cause   = result_ff.pump_cause;

endmodule

// ----- hw/rtl/pmsw_checker.sv -----
`timescale 1ns / 1ps

`include "pump_motion_safety_watchdog_core_assert.svh"

module pmsw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_pump_drive,
   input logic       rsp_pump_enabled,
   input logic       rsp_motion_stop,
   input logic [1:0] rsp_motion_cause,
   input logic [2:0] rsp_pump_cause
);

   `PMSW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_pump_drive, rsp_pump_enabled, rsp_motion_stop, rsp_motion_cause, rsp_pump_cause}))
   `PMSW_ASSERT_IMPLY(a_stop_has_cause, clock, reset, rsp_valid, rsp_motion_stop == (rsp_motion_cause != pmsw_pkg::MCAUSE_NONE))
   `PMSW_ASSERT_IMPLY(a_pump_cause_off, clock, reset, rsp_valid && (rsp_pump_cause != pmsw_pkg::PCAUSE_NONE), !rsp_pump_enabled)
   `PMSW_ASSERT_IMPLY(a_pump_cause_code, clock, reset, rsp_valid, rsp_pump_cause <= pmsw_pkg::PCAUSE_OFF)

endmodule

bind pump_motion_safety_watchdog_core pmsw_checker u_pmsw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pump_drive   (rsp_pump_drive),
   .rsp_pump_enabled (rsp_pump_enabled),
   .rsp_motion_stop  (rsp_motion_stop),
   .rsp_motion_cause (rsp_motion_cause),
   .rsp_pump_cause   (rsp_pump_cause)
);

// ----- bench/pump_motion_safety_watchdog_core_tb.sv -----
`timescale 1ns / 1ps

module pump_motion_safety_watchdog_core_tb;

   localparam logic [3:0] FUNC_UNUSED_LO = pmsw_pkg::FUNC_AGENT_STATE + 4'd1;
   localparam logic [3:0] FUNC_UNUSED_HI = 4'hF;
   localparam int STALL_LIMIT = 2000;

   class watchdog_scoreboard;
      pmsw_pkg::cfg_type    cfg;
      bit                   initialized;
      bit                   link_up;
      bit                   pump_on;
      logic [1:0]           pump_source;
      logic [1:0]           motion_source;
      logic [31:0]          pump_stamp;
      logic [31:0]          motion_stamp;
      pmsw_pkg::result_type expected_q[$];
      int                   errors;
      int                   requests;
      int                   responses;
      int                   stops;
      int                   pump_cuts;
      int                   unused_codes;

      function new();
         cfg.pump_timeout = pmsw_pkg::PUMP_TIMEOUT_RST;
         cfg.motion_timeout = pmsw_pkg::MOTION_TIMEOUT_RST;
         cfg.pump_active_high = 1'b1;
         initialized = 0;
         link_up = 0;
         pump_on = 0;
         pump_source = pmsw_pkg::SRC_NONE;
         motion_source = pmsw_pkg::SRC_NONE;
         pump_stamp = '0;
         motion_stamp = '0;
      endfunction

      function void apply_config(logic [1:0] idx, logic [31:0] data);
         case (idx)
            pmsw_pkg::CSR_PUMP_TIMEOUT:     cfg.pump_timeout = data;
            pmsw_pkg::CSR_MOTION_TIMEOUT:   cfg.motion_timeout = data;
            pmsw_pkg::CSR_PUMP_ACTIVE_HIGH: cfg.pump_active_high = data[0];
            default: ;
         endcase
      endfunction

      function void cut_pump(logic [31:0] now);
         pump_stamp = now;
         pump_source = pmsw_pkg::SRC_NONE;
         if (initialized) pump_on = 0;
      endfunction

      function void halt_motion(logic [31:0] now);
         motion_source = pmsw_pkg::SRC_NONE;
         motion_stamp = now;
      endfunction

      function void note_request(pmsw_pkg::item_type it);
         pmsw_pkg::result_type r;
         logic [31:0]          now;
         r = '0;
         now = it.now_ms;
         requests++;
         case (it.func)
            pmsw_pkg::FUNC_INIT: begin
               initialized = 1;
               link_up = it.agent_link;
               pump_stamp = now;
               pump_source = pmsw_pkg::SRC_NONE;
               motion_stamp = now;
               motion_source = pmsw_pkg::SRC_NONE;
               pump_on = 0;
            end
            pmsw_pkg::FUNC_CHECK: begin
               if (motion_source != pmsw_pkg::SRC_NONE) begin
                  if (motion_source == pmsw_pkg::SRC_AGENT && !link_up) begin
                     halt_motion(now);
                     r.motion_stop = 1'b1;
                     r.motion_cause = pmsw_pkg::MCAUSE_LOST;
                  end else if (cfg.motion_timeout != 0 &&
                               32'(now - motion_stamp) > cfg.motion_timeout) begin
                     halt_motion(now);
                     r.motion_stop = 1'b1;
                     r.motion_cause = pmsw_pkg::MCAUSE_TIMEOUT;
                  end
               end
               if (pump_on && pump_source == pmsw_pkg::SRC_AGENT && !link_up) begin
                  cut_pump(now);
                  r.pump_cause = pmsw_pkg::PCAUSE_LOST;
               end else if (pump_on && cfg.pump_timeout != 0 &&
                            32'(now - pump_stamp) > cfg.pump_timeout) begin
                  cut_pump(now);
                  r.pump_cause = pmsw_pkg::PCAUSE_TIMEOUT;
               end
            end
            pmsw_pkg::FUNC_AGENT_PUMP: begin
               pump_stamp = now;
               if (it.pump_request_on && !link_up) begin
                  cut_pump(now);
                  r.pump_cause = pmsw_pkg::PCAUSE_REJECTED;
               end else begin
                  pump_source = it.pump_request_on ? pmsw_pkg::SRC_AGENT : pmsw_pkg::SRC_NONE;
                  if (initialized) pump_on = it.pump_request_on;
               end
            end
            pmsw_pkg::FUNC_WEB_PUMP: begin
               pump_stamp = now;
               pump_source = it.pump_request_on ? pmsw_pkg::SRC_WEB : pmsw_pkg::SRC_NONE;
               if (initialized) pump_on = it.pump_request_on;
            end
            pmsw_pkg::FUNC_PUMP_OFF: begin
               cut_pump(now);
               r.pump_cause = pmsw_pkg::PCAUSE_OFF;
            end
            pmsw_pkg::FUNC_MOTION_STOP: begin
               halt_motion(now);
               r.motion_stop = 1'b1;
               r.motion_cause = pmsw_pkg::MCAUSE_STOP;
            end
            pmsw_pkg::FUNC_AGENT_MOTION: begin
               motion_stamp = now;
               motion_source = pmsw_pkg::SRC_AGENT;
            end
            pmsw_pkg::FUNC_WEB_MOTION: begin
               motion_stamp = now;
               motion_source = pmsw_pkg::SRC_WEB;
            end
            pmsw_pkg::FUNC_AGENT_STATE: begin
               link_up = it.agent_link;
               if (!link_up && motion_source == pmsw_pkg::SRC_AGENT) begin
                  halt_motion(now);
                  r.motion_stop = 1'b1;
                  r.motion_cause = pmsw_pkg::MCAUSE_LOST;
               end
               if (!link_up && pump_source == pmsw_pkg::SRC_AGENT) begin
                  cut_pump(now);
                  r.pump_cause = pmsw_pkg::PCAUSE_LOST;
               end
            end
            default: unused_codes++;
         endcase
         r.pump_enabled = pump_on;
         r.pump_drive = pump_on ? cfg.pump_active_high : ~cfg.pump_active_high;
         if (r.motion_stop) stops++;
         if (r.pump_cause != pmsw_pkg::PCAUSE_NONE) pump_cuts++;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at response %0d: %s", responses, msg);
         errors++;
      endtask

      task check_response(pmsw_pkg::result_type got);
         pmsw_pkg::result_type want;
         responses++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("no request outstanding, got %p", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.pump_drive !== want.pump_drive)
            report_mismatch($sformatf("pump_drive %b, want %b", got.pump_drive,
                                      want.pump_drive));
         if (got.pump_enabled !== want.pump_enabled)
            report_mismatch($sformatf("pump_enabled %b, want %b", got.pump_enabled,
                                      want.pump_enabled));
         if (got.motion_stop !== want.motion_stop)
            report_mismatch($sformatf("motion_stop %b, want %b", got.motion_stop,
                                      want.motion_stop));
         if (got.motion_cause !== want.motion_cause)
            report_mismatch($sformatf("motion_cause %0d, want %0d", got.motion_cause,
                                      want.motion_cause));
         if (got.pump_cause !== want.pump_cause)
            report_mismatch($sformatf("pump_cause %0d, want %0d", got.pump_cause,
                                      want.pump_cause));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_func = '0;
   logic [31:0] req_now_ms = '0;
   logic        req_pump_request_on = 1'b0;
   logic        req_agent_link = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_pump_drive;
   logic        rsp_pump_enabled;
   logic        rsp_motion_stop;
   logic [1:0]  rsp_motion_cause;
   logic [2:0]  rsp_pump_cause;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   watchdog_scoreboard sb = new();
   bit          req_idle_on = 1;
   bit          rsp_idle_on = 1;
   logic [31:0] now_cursor;
   logic [31:0] step_span;
   int          settings;
   int          idle_cycles;

   pump_motion_safety_watchdog_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_now_ms          (req_now_ms),
      .req_pump_request_on (req_pump_request_on),
      .req_agent_link      (req_agent_link),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pump_drive      (rsp_pump_drive),
      .rsp_pump_enabled    (rsp_pump_enabled),
      .rsp_motion_stop     (rsp_motion_stop),
      .rsp_motion_cause    (rsp_motion_cause),
      .rsp_pump_cause      (rsp_pump_cause),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pmsw_pkg::item_type make_request(logic [3:0] func, logic [31:0] now,
                                                       logic req_on, logic conn);
      pmsw_pkg::item_type it;
      it.func = func;
      it.now_ms = now;
      it.pump_request_on = req_on;
      it.agent_link = conn;
      return it;
   endfunction

   function automatic pmsw_pkg::item_type random_request();
      pmsw_pkg::item_type it;
      int unsigned        pick;
      pick = $urandom_range(99);
      if (pick < 3)       it.func = pmsw_pkg::FUNC_INIT;
      else if (pick < 30) it.func = pmsw_pkg::FUNC_CHECK;
      else if (pick < 40) it.func = pmsw_pkg::FUNC_AGENT_PUMP;
      else if (pick < 50) it.func = pmsw_pkg::FUNC_WEB_PUMP;
      else if (pick < 55) it.func = pmsw_pkg::FUNC_PUMP_OFF;
      else if (pick < 60) it.func = pmsw_pkg::FUNC_MOTION_STOP;
      else if (pick < 70) it.func = pmsw_pkg::FUNC_AGENT_MOTION;
      else if (pick < 78) it.func = pmsw_pkg::FUNC_WEB_MOTION;
      else if (pick < 94) it.func = pmsw_pkg::FUNC_AGENT_STATE;
      else                it.func = 4'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
      if ($urandom_range(19) == 0) now_cursor = $urandom;
      else now_cursor = now_cursor + $urandom_range(step_span, 0);
      it.now_ms = now_cursor;
      it.pump_request_on = ($urandom_range(9) < 7);
      it.agent_link = ($urandom_range(9) < 6);
      return it;
   endfunction

   task automatic send_request(input pmsw_pkg::item_type it);
      while (req_idle_on && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_now_ms <= it.now_ms;
      req_pump_request_on <= it.pump_request_on;
      req_agent_link <= it.agent_link;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.apply_config(idx, data);
   endtask

   task automatic configure(input logic [31:0] pt, input logic [31:0] mt, input logic ah);
      wait_drained();
      write_csr(pmsw_pkg::CSR_PUMP_TIMEOUT, pt);
      write_csr(pmsw_pkg::CSR_MOTION_TIMEOUT, mt);
      write_csr(pmsw_pkg::CSR_PUMP_ACTIVE_HIGH, {31'b0, ah});
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic run_phase(input logic [31:0] pt, input logic [31:0] mt, input logic ah,
                            input logic [31:0] span, input int count, input bit idle);
      configure(pt, mt, ah);
      step_span = span;
      req_idle_on = idle;
      rsp_idle_on = idle;
      for (int n = 0; n < count; n++) begin
         // hold off mid-phase until the pipeline is empty
         if (idle && n == count / 2) wait_drained();
         send_request(random_request());
      end
   endtask

   // response side
   initial begin
      pmsw_pkg::result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.pump_drive = rsp_pump_drive;
            got.pump_enabled = rsp_pump_enabled;
            got.motion_stop = rsp_motion_stop;
            got.motion_cause = rsp_motion_cause;
            got.pump_cause = rsp_pump_cause;
            sb.check_response(got);
         end
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 27);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      now_cursor = $urandom;
      step_span = 200;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: pump timeout off, motion timeout 500, active high
      send_request(make_request(pmsw_pkg::FUNC_WEB_PUMP, 32'd0, 1'b1, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_PUMP, 32'd5, 1'b1, 1'b1));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 1'b0, 1'b0));
      send_request(make_request(FUNC_UNUSED_LO, 32'h1234_5678, 1'b1, 1'b1));
      send_request(make_request(pmsw_pkg::FUNC_INIT, 32'd1000, 1'b0, 1'b1));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_PUMP, 32'd1010, 1'b1, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_MOTION, 32'd1020, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'd1520, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'd1521, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_WEB_MOTION, 32'd2000, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_MOTION_STOP, 32'd2001, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_MOTION, 32'd2100, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_STATE, 32'd2200, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_PUMP, 32'd2300, 1'b1, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_WEB_PUMP, 32'd2400, 1'b1, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_MOTION, 32'd2500, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'd2600, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_PUMP_OFF, 32'd2700, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_AGENT_PUMP, 32'd2800, 1'b0, 1'b1));
      send_request(make_request(pmsw_pkg::FUNC_INIT, 32'hFFFF_FFFF, 1'b1, 1'b0));
      send_request(make_request(FUNC_UNUSED_HI, 32'd0, 1'b1, 1'b1));

      // pump timeout across the counter wrap, active low pin
      configure(32'd100, 32'd0, 1'b0);
      send_request(make_request(pmsw_pkg::FUNC_INIT, 32'hFFFF_FFC0, 1'b0, 1'b1));
      send_request(make_request(pmsw_pkg::FUNC_WEB_PUMP, 32'hFFFF_FFD0, 1'b1, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_WEB_MOTION, 32'hFFFF_FFD0, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'h0000_0020, 1'b0, 1'b0));
      send_request(make_request(pmsw_pkg::FUNC_CHECK, 32'h0000_0035, 1'b0, 1'b0));

      run_phase($urandom_range(300, 50), $urandom_range(300, 50), 1'b1, 32'd200, 150, 1);
      run_phase(32'hFFFF_FFFF, 32'd0, 1'b0, 32'd1_000_000, 150, 1);
      run_phase(32'd1, 32'd1, 1'($urandom_range(1)), 32'd3, 150, 1);
      run_phase(32'd0, 32'hFFFF_FFFF, 1'b1, 32'd300, 150, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests over %0d register settings (%0d unused codes).",
               sb.requests, settings, sb.unused_codes);
      $display("Predicted %0d motion stops and %0d pump shutdowns; %0d mismatches.",
               sb.stops, sb.pump_cuts, sb.errors);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pmsw_pkg.sv
hw/rtl/pmsw_cfg.sv
hw/rtl/pmsw_engine.sv
hw/rtl/pump_motion_safety_watchdog_core.sv
hw/rtl/pmsw_checker.sv
bench/pump_motion_safety_watchdog_core_tb.sv
